FILE: sv/spherical_texcoord_wrap_top_defines.svh
// Assertion macros for the spherical texture-coordinate block.
`ifndef SPHERICAL_TEXCOORD_WRAP_TOP_DEFINES_SVH
`define SPHERICAL_TEXCOORD_WRAP_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define STW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define STW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/stw_pkg.sv
// Package for the spherical texture-coordinate block: sizes and arctangent table.
`default_nettype none
package stw_pkg;
  localparam int COORD_WIDTH_DEF  = 32;
  localparam int UV_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 18;
  // CORDIC datapath width: offsets scaled to 57 bits plus growth headroom
  localparam int DW = 60;
  localparam int AW = 35;
  localparam int GUARD_SUM = 56;
  localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;
  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;

  // atan(2^-i) in turns, 2^32 per turn
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
        5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
        5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
        5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
        5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
        5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
        5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
        5'd30: r = 32'h00000001;
        default: r = 32'h00000000;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

FILE: sv/stw_if.sv
// Valid/ready channel interfaces for the spherical texture-coordinate block.
`default_nettype none
interface stw_point_if #(parameter int CW = 32) ();
  logic valid;
  logic ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface stw_uv_if #(parameter int FB = 16) ();
  logic valid;
  logic ready;
  logic [FB:0] tex_u;
  logic [FB:0] tex_v;
  logic degenerate;
  modport source (output valid, tex_u, tex_v, degenerate, input ready);
  modport sink (input valid, tex_u, tex_v, degenerate, output ready);
endinterface

interface stw_cfg_if #(parameter int CW = 32) ();
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [CW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/spherical_texcoord_wrap_top.sv
// Spherical texture-coordinate generator: pipelined dual CORDIC.
// Takes one vertex per cycle while the output is not stalled and returns its (u,v);
// throughput is one item per cycle, set by the one
// CORDIC iteration per register stage in both the yaw and the pitch CORDIC.
// The whole pipeline advances together and freezes while the output holds a
// result that is not taken. Centre registers reset to zero.
`default_nettype none
module spherical_texcoord_wrap_top #(
  parameter int COORD_WIDTH  = stw_pkg::COORD_WIDTH_DEF,
  parameter int UV_FRAC_BITS = stw_pkg::UV_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = stw_pkg::CORDIC_STEPS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  stw_cfg_if.sink cfg,
  stw_point_if.sink pin,
  stw_uv_if.source uvout
);
  import stw_pkg::*;
  `include "spherical_texcoord_wrap_top_defines.svh"

  localparam int N  = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int F  = UV_FRAC_BITS;
  localparam int GB = GUARD_SUM - COORD_WIDTH;
  localparam int OW = COORD_WIDTH + 1;
  // stages: 1 offsets, 1 prerotate, N yaw iters, 2 gain mult, 1 prerot, N pitch, 1 out
  localparam int NS = 2 * N + 6;

  logic signed [COORD_WIDTH-1:0] center_x, center_y, center_z;

  // configuration writes
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
    end else if (cfg.valid) begin
      case ({1'b0, cfg.index})
        REG_CENTER_X: center_x <= cfg.data;
        REG_CENTER_Y: center_y <= cfg.data;
        REG_CENTER_Z: center_z <= cfg.data;
        default: ;
      endcase
    end
  end

  // global stall: advance when output slot free or taken
  logic adv;
  logic [NS-1:0] vld;
  assign adv = !uvout.valid || uvout.ready;
  assign pin.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NS-2:0], pin.valid};
  end

  // stage 0: offsets
  logic signed [OW-1:0] s0_dx, s0_dy, s0_dz;
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_dx <= OW'(pin.point_x) - OW'(center_x);
      s0_dy <= OW'(pin.point_y) - OW'(center_y);
      s0_dz <= OW'(pin.point_z) - OW'(center_z);
    end
  end

  // stage 1: scale, yaw pre-rotation into right half plane
  logic signed [DW-1:0] yx [0:N];
  logic signed [DW-1:0] yy [0:N];
  logic signed [AW-1:0] ya [0:N];
  logic signed [DW-1:0] dyc [0:N];
  logic                 dg [0:2*N+3];
  logic signed [DW-1:0] sx, sz, sy;
  assign sx = DW'(s0_dx) <<< GB;
  assign sz = DW'(s0_dz) <<< GB;
  assign sy = DW'(s0_dy) <<< GB;
  always_ff @(posedge clk) begin
    if (adv) begin
      if (sx < 0) begin
        yx[0] <= -sx;
        yy[0] <= -sz;
        ya[0] <= (sz >= 0) ? AW'(64'sh80000000) : -AW'(64'sh80000000);
      end else begin
        yx[0] <= sx;
        yy[0] <= sz;
        ya[0] <= '0;
      end
      dyc[0] <= sy;
      dg[0] <= (s0_dx == 0) && (s0_dy == 0) && (s0_dz == 0);
    end
  end

  // yaw CORDIC iterations, one per stage
  for (genvar i = 0; i < N; i++) begin : g_yaw
    always_ff @(posedge clk) begin
      if (adv) begin
        if (yy[i] > 0) begin
          yx[i+1] <= yx[i] + (yy[i] >>> i);
          yy[i+1] <= yy[i] - (yx[i] >>> i);
          ya[i+1] <= ya[i] + AW'(atan_turns(5'(i)));
        end else begin
          yx[i+1] <= yx[i] - (yy[i] >>> i);
          yy[i+1] <= yy[i] + (yx[i] >>> i);
          ya[i+1] <= ya[i] - AW'(atan_turns(5'(i)));
        end
        dyc[i+1] <= dyc[i];
        dg[i+1] <= dg[i];
      end
    end
  end

  // gain compensation: two products (28x32 and 32x32), then sum
  logic [63:0] gp_hi, gp_lo;
  logic [DW-1:0] gm;
  logic signed [AW-1:0] yaw_g1, yaw_g2;
  logic signed [DW-1:0] dy_g1, dy_g2, gh;
  assign gm = yx[N];
  always_ff @(posedge clk) begin
    if (adv) begin
      gp_hi <= 64'(gm[DW-1:32]) * 64'(INV_GAIN_Q32);
      gp_lo <= 64'(gm[31:0]) * 64'(INV_GAIN_Q32);
      yaw_g1 <= ya[N];
      dy_g1 <= dyc[N];
      dg[N+1] <= dg[N];
      gh <= DW'(gp_hi) + DW'(gp_lo[63:32]);
      yaw_g2 <= yaw_g1;
      dy_g2 <= dy_g1;
      dg[N+2] <= dg[N+1];
    end
  end

  // pitch CORDIC: x = h >= 0, so no pre-rotation needed
  logic signed [DW-1:0] px [0:N];
  logic signed [DW-1:0] py [0:N];
  logic signed [AW-1:0] pa [0:N];
  logic signed [AW-1:0] yw [0:N];
  always_ff @(posedge clk) begin
    if (adv) begin
      px[0] <= gh;
      py[0] <= dy_g2;
      pa[0] <= '0;
      yw[0] <= yaw_g2;
      dg[N+3] <= dg[N+2];
    end
  end
  for (genvar i = 0; i < N; i++) begin : g_pitch
    always_ff @(posedge clk) begin
      if (adv) begin
        if (py[i] > 0) begin
          px[i+1] <= px[i] + (py[i] >>> i);
          py[i+1] <= py[i] - (px[i] >>> i);
          pa[i+1] <= pa[i] + AW'(atan_turns(5'(i)));
        end else begin
          px[i+1] <= px[i] - (py[i] >>> i);
          py[i+1] <= py[i] + (px[i] >>> i);
          pa[i+1] <= pa[i] - AW'(atan_turns(5'(i)));
        end
        yw[i+1] <= yw[i];
        dg[N+4+i] <= dg[N+3+i];
      end
    end
  end

  // output stage: clamp, round, map to [0,1]
  localparam logic signed [AW-1:0] HT = AW'(64'sh80000000);
  localparam logic signed [AW-1:0] QT = AW'(64'sh40000000);
  logic signed [AW-1:0] yc, pc, ysum, psum, uq, vq;
  always_comb begin
    yc = yw[N];
    if (yc < -HT) yc = -HT;
    if (yc > HT) yc = HT;
    pc = pa[N];
    if (pc < -QT) pc = -QT;
    if (pc > QT) pc = QT;
    ysum = yc + HT + (AW'(1) <<< (31 - F));
    psum = pc + QT + (AW'(1) <<< (30 - F));
    uq = ysum >>> (32 - F);
    vq = psum >>> (31 - F);
    if (uq > (AW'(1) <<< F)) uq = AW'(1) <<< F;
    if (vq > (AW'(1) <<< F)) vq = AW'(1) <<< F;
  end

  logic [F:0] half;
  assign half = (F+1)'(1) << (F - 1);
  always_ff @(posedge clk) begin
    if (adv) begin
      uvout.tex_u <= dg[2*N+3] ? half : uq[F:0];
      uvout.tex_v <= dg[2*N+3] ? half : vq[F:0];
      uvout.degenerate <= dg[2*N+3];
    end
  end
  assign uvout.valid = vld[NS-1];

  // checks
  `STW_ASSERT_NEXT(a_hold, clk, rst, uvout.valid && !uvout.ready,
    uvout.valid && $stable(uvout.tex_u) && $stable(uvout.tex_v), "output changed while stalled")
  `STW_ASSERT_IMP(a_u_range, clk, rst, uvout.valid,
    uvout.tex_u <= ((F+1)'(1) << F) && uvout.tex_v <= ((F+1)'(1) << F), "uv out of range")
  `STW_ASSERT_IMP(a_deg_half, clk, rst, uvout.valid && uvout.degenerate,
    uvout.tex_u == half && uvout.tex_v == half, "degenerate result not centered")
  `STW_ASSERT_IMP(a_ready, clk, rst, !uvout.valid, pin.ready, "input blocked with empty output")
endmodule
`default_nettype wire

FILE: tb/sv/tb_spherical_texcoord_wrap_top.sv
// Testbench for the spherical texture-coordinate block: random and directed vertices checked against a CORDIC predictor.
module tb_spherical_texcoord_wrap_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stw_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int STEPS = 18;
  localparam int LATENCY = 2 * STEPS + 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [FB:0] tex_u;
    logic [FB:0] tex_v;
    logic        degenerate;
  } uv_t;

  // Expected texture coordinates per accepted vertex, checked in order
  class uv_scoreboard;
    longint ctr_x, ctr_y, ctr_z;
    uv_t    pending_uv[$];
    int     mismatches;
    int     checked;
    int     degen_seen;
    longint atan_tab[STEPS];

    function new();
      atan_tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                   64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                   64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                   64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
                   64'h000028BE, 64'h0000145F};
      ctr_x = 0; ctr_y = 0; ctr_z = 0;
      mismatches = 0; checked = 0; degen_seen = 0;
    endfunction

    function void set_center(logic [1:0] idx, logic [CW-1:0] val);
      longint s;
      s = longint'(signed'(val));
      case (idx)
        REG_CENTER_X[1:0]: ctr_x = s;
        REG_CENTER_Y[1:0]: ctr_y = s;
        REG_CENTER_Z[1:0]: ctr_z = s;
        default: ;
      endcase
    endfunction

    // Vectoring rotation: angle in turns (2^32 per turn), gain-scaled magnitude
    function longint vec_angle(longint x0, longint y0, output longint mag);
      longint x, y, a, xs, ys;
      x = x0; y = y0; a = 0;
      if (x < 0) begin
        a = (y >= 0) ? 64'sh80000000 : -64'sh80000000;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; a = a + atan_tab[i];
        end else begin
          x = x - ys; y = y + xs; a = a - atan_tab[i];
        end
      end
      mag = x;
      return a;
    endfunction

    function void note_point(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz);
      longint dx, dy, dz, yaw, pitch, mag, mag2, q;
      longint unsigned m, h;
      uv_t e;
      dx = longint'(signed'(px)) - ctr_x;
      dy = longint'(signed'(py)) - ctr_y;
      dz = longint'(signed'(pz)) - ctr_z;
      if (dx == 0 && dy == 0 && dz == 0) begin
        e.tex_u = 17'd1 << (FB - 1);
        e.tex_v = 17'd1 << (FB - 1);
        e.degenerate = 1'b1;
        degen_seen++;
      end else begin
        yaw = vec_angle(dx <<< (56 - CW), dz <<< (56 - CW), mag);
        m = longint'(mag);
        // undo CORDIC gain before the pitch rotation
        h = (m >> 32) * 64'h9B74EDA8 + (((m & 64'hFFFFFFFF) * 64'h9B74EDA8) >> 32);
        pitch = vec_angle(longint'(h), dy <<< (56 - CW), mag2);
        if (yaw < -64'sh80000000) yaw = -64'sh80000000;
        if (yaw > 64'sh80000000) yaw = 64'sh80000000;
        if (pitch < -64'sh40000000) pitch = -64'sh40000000;
        if (pitch > 64'sh40000000) pitch = 64'sh40000000;
        q = (yaw + 64'sh80000000 + (64'sd1 << (31 - FB))) >>> (32 - FB);
        if (q < 0) q = 0;
        if (q > (64'sd1 << FB)) q = 64'sd1 << FB;
        e.tex_u = q[FB:0];
        q = (pitch + 64'sh40000000 + (64'sd1 << (30 - FB))) >>> (31 - FB);
        if (q < 0) q = 0;
        if (q > (64'sd1 << FB)) q = 64'sd1 << FB;
        e.tex_v = q[FB:0];
        e.degenerate = 1'b0;
      end
      pending_uv = {pending_uv, e};
    endfunction

    function void check_uv(uv_t got);
      uv_t e;
      checked++;
      if (pending_uv.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result u=%0d v=%0d degen=%0b",
                   got.tex_u, got.tex_v, got.degenerate);
        return;
      end
      e = pending_uv.pop_front();
      if (e != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d expected u=%0d v=%0d degen=%0b, got u=%0d v=%0d degen=%0b",
                   checked, e.tex_u, e.tex_v, e.degenerate,
                   got.tex_u, got.tex_v, got.degenerate);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  stw_cfg_if   #(.CW(CW)) cfg_if ();
  stw_point_if #(.CW(CW)) pin_if ();
  stw_uv_if    #(.FB(FB)) uv_if ();

  spherical_texcoord_wrap_top dut (
    .clk(clk), .rst(rst), .cfg(cfg_if), .pin(pin_if), .uvout(uv_if)
  );

  uv_scoreboard sb = new();
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int points_sent = 0;
  logic [CW-1:0] cur_cx = '0, cur_cy = '0, cur_cz = '0;

  always #5 clk = ~clk;

  initial begin
    cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
    pin_if.valid = 1'b0; pin_if.point_x = '0; pin_if.point_y = '0; pin_if.point_z = '0;
    uv_if.ready = 1'b0;
  end

  // Result side: random stalls, optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      uv_if.ready <= 1'b0;
    end else if (hold_req || hold_left > 0) begin
      if (hold_req && hold_left == 0) hold_left <= HOLD_CYCLES;
      else hold_left <= hold_left - 1;
      if (hold_left == 1) hold_req <= 1'b0;
      uv_if.ready <= 1'b0;
    end else begin
      uv_if.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 17);
    end
  end

  // Transfer monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_center(cfg_if.index, cfg_if.data);
      if (pin_if.valid && pin_if.ready)
        sb.note_point(pin_if.point_x, pin_if.point_y, pin_if.point_z);
      if (uv_if.valid && uv_if.ready)
        sb.check_uv('{uv_if.tex_u, uv_if.tex_v, uv_if.degenerate});
      if ((cfg_if.valid && cfg_if.ready) || (pin_if.valid && pin_if.ready) ||
          (uv_if.valid && uv_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", quiet_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_center(logic [1:0] idx, logic [CW-1:0] val);
    bit got;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do begin
      @(negedge clk); got = cfg_if.ready;
      @(posedge clk);
    end while (!got);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_CENTER_X[1:0]: cur_cx = val;
      REG_CENTER_Y[1:0]: cur_cy = val;
      REG_CENTER_Z[1:0]: cur_cz = val;
      default: ;
    endcase
  endtask

  task automatic send_point(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz);
    bit got;
    while (!no_idle && $urandom_range(0, 99) < 17) begin
      pin_if.valid <= 1'b0;
      @(posedge clk);
    end
    pin_if.valid   <= 1'b1;
    pin_if.point_x <= px;
    pin_if.point_y <= py;
    pin_if.point_z <= pz;
    do begin
      @(negedge clk); got = pin_if.ready;
      @(posedge clk);
    end while (!got);
    points_sent++;
  endtask

  // Sender stops until every result is back, then lets the pipeline settle
  task automatic drain();
    pin_if.valid <= 1'b0;
    while (sb.pending_uv.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] small_off(logic [CW-1:0] c);
    return c + CW'($urandom_range(0, 2000)) - CW'(1000);
  endfunction

  // Mostly full-range vertices, plus points near the centre, on its y axis or x or z plane, and on it
  task automatic send_random_point();
    int mode;
    logic [CW-1:0] px, py, pz;
    mode = $urandom_range(0, 9);
    px = $urandom(); py = $urandom(); pz = $urandom();
    if (mode == 6 || mode == 7) begin
      px = small_off(cur_cx); py = small_off(cur_cy); pz = small_off(cur_cz);
    end else if (mode == 8) begin
      case ($urandom_range(0, 2))
        0: begin px = cur_cx; pz = cur_cz; end
        1: pz = cur_cz;
        default: px = cur_cx;
      endcase
    end else if (mode == 9) begin
      px = cur_cx; py = cur_cy; pz = cur_cz;
    end
    send_point(px, py, pz);
  endtask

  task automatic send_directed();
    logic [CW-1:0] mx, mn;
    mx = 32'h7FFFFFFF; mn = 32'h80000000;
    send_point(cur_cx, cur_cy, cur_cz);                     // point on centre
    send_point(cur_cx, cur_cy + 32'h00010000, cur_cz);      // straight up
    send_point(cur_cx, cur_cy - 32'h00010000, cur_cz);      // straight down
    send_point(cur_cx - 32'h00010000, cur_cy, cur_cz);      // negative x axis
    send_point(cur_cx + 32'h00010000, cur_cy, cur_cz);      // positive x axis
    send_point(cur_cx, cur_cy, cur_cz + 32'h00010000);
    send_point(cur_cx, cur_cy, cur_cz - 32'h00010000);
    send_point(cur_cx - 32'd1, cur_cy + 32'd1, cur_cz);
    send_point(mx, mx, mx);
    send_point(mn, mn, mn);
    send_point(mx, mn, mx);
    send_point(mn, mx, mn);
    send_point(mn, 32'd0, mx);
    send_point(mx, mx, mn);
    send_point(32'd0, 32'd0, 32'd0);
    send_point(32'hFFFFFFFF, 32'd1, 32'hFFFFFFFF);
  endtask

  initial begin
    logic [CW-1:0] cx, cy, cz;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset centre: directed then random
    send_directed();
    repeat (250) send_random_point();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin cx = 32'h7FFFFFFF; cy = 32'h80000000; cz = 32'h7FFFFFFF; end
        1: begin cx = 32'h80000000; cy = 32'h7FFFFFFF; cz = 32'h80000000; end
        2: begin cx = 32'd0; cy = 32'd0; cz = 32'd0; end
        3: begin cx = 32'hFFFFFFFF; cy = 32'h00010000; cz = 32'hFFFF0000; end
        default: begin cx = $urandom(); cy = $urandom(); cz = $urandom(); end
      endcase
      write_center(REG_CENTER_X[1:0], cx);
      write_center(REG_CENTER_Y[1:0], cy);
      write_center(REG_CENTER_Z[1:0], cz);
      // unmapped register index must be ignored
      if (ph == 1 || ph == 4) write_center(2'd3, $urandom());
      @(posedge clk);
      if (ph == 0 || ph == 1) send_directed();
      no_idle = (ph == 3);
      if (ph == 2) begin
        hold_req <= 1'b1;
        repeat (150) send_random_point();
      end
      repeat (280) send_random_point();
      no_idle = 1'b0;
      drain();
    end

    $display("Covered %0d vertices (%0d on centre) under 7 centre settings,",
             points_sent, sb.degen_seen);
    $display("with random stalls, a long output hold-off and a stall-free phase.");
    if (sb.mismatches == 0 && sb.pending_uv.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_uv.size());
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: spherical_texcoord_wrap_top.f
+incdir+sv
sv/stw_pkg.sv
sv/stw_if.sv
sv/spherical_texcoord_wrap_top.sv
tb/sv/tb_spherical_texcoord_wrap_top.sv
